@@ rtl/core/icdf_pkg.sv @@
package icdf_pkg;

   localparam int INDEX_W     = 10;
   localparam int VALUE_W     = 25;
   localparam int PROB_W      = 24;
   localparam int SAMPLE_W    = 32;
   localparam int STEPS_W     = 11;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int MAG_W       = 33;
   localparam int ALU_W       = 34;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MIN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAX    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_T_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_T_MAX = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS = 2'd2;

   localparam logic [SAMPLE_W-1:0] T_MIN_RESET = 32'd0;
   localparam logic [SAMPLE_W-1:0] T_MAX_RESET = 32'd65536;
   localparam logic [STEPS_W-1:0]  STEPS_RESET = 11'd1024;

   typedef struct packed {
      logic               req_type;
      logic [INDEX_W-1:0] entry_index;
      logic [VALUE_W-1:0] entry_value;
      logic [PROB_W-1:0]  uniform;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [KIND_W-1:0]          clamp_kind;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [SAMPLE_W-1:0]    value;
   } csr_payload_type;

endpackage

@@ rtl/core/icdf_stream_if.sv @@
interface icdf_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

@@ rtl/core/inverse_cdf_table_sampler.sv @@
// Tabulated inverse-CDF sampler.
// Channels: req carries load beats (req_type 0: write entry_value, Q1.24, to
// entry_index) and sample beats (req_type 1: map uniform, Q0.24, to a sample).
// rsp carries one beat per sample beat: sample_value in signed Q16.16 and
// clamp_kind. csr writes t_min, t_max and steps_in_use; it is always ready.
// A load beat gives no rsp beat and leaves req ready. A sample beat below entry 0
// goes from the entry-0 check straight to the output state; one at or above the
// last used entry goes there after the last-entry check. An interpolated sample
// runs through the binary search, the bin reads, the span, the fraction divide,
// the multiply, the divide by steps and the final add: one shared 34-bit adder
// runs the binary search compares, the bin fraction divide (one bit a cycle), the
// shift-add multiply (one bit a cycle) and the divide by steps (one bit a cycle).
// req is ready only while the sequencer is idle, again from the cycle in which
// the result enters the rsp output register. While rsp stalls, the block still
// takes the next req beat and holds its own result until the register frees up.
// Reset clears the sequencer and rsp valid and restores the register defaults;
// table entries stay undefined until loaded.
module inverse_cdf_table_sampler #(
   parameter int TABLE_DEPTH    = 1024,
   parameter int PROB_FRAC_BITS = 24
) (
   input logic           clock,
   input logic           reset,
   icdf_stream_if.sink   req,
   icdf_stream_if.source rsp,
   icdf_stream_if.sink   csr
);

   import icdf_pkg::*;

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int N_W     = $clog2(TABLE_DEPTH + 1);
   localparam int FRAC_W  = PROB_FRAC_BITS;
   localparam int POS_W   = IDX_W + FRAC_W;
   localparam int DVD_W   = MAG_W + IDX_W;
   localparam int CNT_MAX = (DVD_W > POS_W) ? DVD_W : POS_W;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_SEARCH,
      ST_COMPARE,
      ST_READ_LO,
      ST_READ_HI,
      ST_SPAN,
      ST_MAG,
      ST_FRAC,
      ST_MUL,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] t_min_ff, t_min_in;
   logic signed [SAMPLE_W-1:0] t_max_ff, t_max_in;
   logic [STEPS_W-1:0]         steps_ff, steps_in;
   logic [PROB_W-1:0]          p_ff, p_in;
   logic [IDX_W-1:0]           a_ff, a_in;
   logic [IDX_W-1:0]           b_ff, b_in;
   logic [IDX_W-1:0]           mid_ff, mid_in;
   logic [VALUE_W-1:0]         lo_ff, lo_in;
   logic [VALUE_W-1:0]         rem_ff, rem_in;
   logic [VALUE_W-1:0]         dsr_ff, dsr_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic                       span_neg_ff, span_neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [MAG_W-1:0]           acc_ff, acc_in;
   logic [POS_W-1:0]           mlt_ff, mlt_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [N_W-1:0]             drem_ff, drem_in;
   logic                       sticky_ff, sticky_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   rsp_payload_type            res_ff, res_in;
   rsp_payload_type            rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]         rd_q_ff;

   logic [VALUE_W-1:0] cdf_mem [TABLE_DEPTH];

   logic [ALU_W-1:0] alu_a;
   logic [ALU_W-1:0] alu_b;
   logic             alu_inv;
   logic             alu_cin;
   logic [ALU_W:0]   alu_sum;
   logic             alu_ge;

   logic [31:0]      steps_ext;
   logic [N_W-1:0]   n_c;
   logic [IDX_W-1:0] last_c;
   logic [IDX_W-1:0] diff_c;
   logic [IDX_W-1:0] mid_c;
   logic             far_c;
   logic [31:0]      wr_idx;
   logic             mem_we;
   logic [IDX_W-1:0] rd_addr;
   logic [N_W:0]     div_shift;
   logic             inexact;
   logic             req_accept;

   assign req_accept = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign csr.ready  = 1'b1;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.data   = rsp_data_ff;

   assign steps_ext = 32'(steps_ff);
   assign n_c = (steps_ext < 32'd2) ? N_W'(2) :
                (steps_ext > 32'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : N_W'(steps_ext);
   assign last_c = IDX_W'(n_c - N_W'(1));
   assign diff_c = b_ff - a_ff;
   assign mid_c  = a_ff + (diff_c >> 1);
   assign far_c  = diff_c > IDX_W'(1);

   assign wr_idx = 32'(req.data.entry_index);
   assign mem_we = req_accept && (req.data.req_type == REQ_LOAD)
                   && (wr_idx < 32'(TABLE_DEPTH));

   assign div_shift = {drem_ff, dvd_ff[DVD_W-1]};
   assign inexact   = sticky_ff || (drem_ff != '0);

   assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_inv ? ~alu_b : alu_b)}
                    + (ALU_W + 1)'(alu_cin);
   assign alu_ge  = alu_sum[ALU_W];

   always_comb begin
      rd_addr = '0;
      case (state_ff)
         ST_CHK_FIRST: rd_addr = last_c;
         ST_SEARCH:    rd_addr = far_c ? mid_c : a_ff;
         ST_READ_LO:   rd_addr = b_ff;
         default:      rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cdf_mem[wr_idx[IDX_W-1:0]] <= req.data.entry_value;
      end
      rd_q_ff <= cdf_mem[rd_addr];
   end

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_inv = 1'b0;
      alu_cin = 1'b0;
      case (state_ff)
         ST_CHK_FIRST, ST_CHK_LAST, ST_COMPARE, ST_READ_LO: begin
            alu_a   = ALU_W'(p_ff);
            alu_b   = ALU_W'(rd_q_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_READ_HI: begin
            alu_a   = ALU_W'(rd_q_ff);
            alu_b   = ALU_W'(lo_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_SPAN: begin
            alu_a   = ALU_W'(t_max_ff);
            alu_b   = ALU_W'(t_min_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_MAG: begin
            alu_a   = '0;
            alu_b   = ALU_W'($signed(mag_ff));
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_FRAC: begin
            alu_a   = ALU_W'({rem_ff, 1'b0});
            alu_b   = ALU_W'(dsr_ff);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_MUL: begin
            alu_a = ALU_W'(acc_ff);
            alu_b = mlt_ff[0] ? ALU_W'(mag_ff) : '0;
         end
         ST_DIV: begin
            alu_a   = ALU_W'(div_shift);
            alu_b   = ALU_W'(n_c);
            alu_inv = 1'b1;
            alu_cin = 1'b1;
         end
         ST_FINISH: begin
            alu_a   = ALU_W'(t_min_ff);
            alu_b   = ALU_W'(dvd_ff[MAG_W-1:0]);
            alu_inv = span_neg_ff;
            alu_cin = span_neg_ff && !inexact;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      t_min_in     = t_min_ff;
      t_max_in     = t_max_ff;
      steps_in     = steps_ff;
      p_in         = p_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      frac_in      = frac_ff;
      span_neg_in  = span_neg_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      mlt_in       = mlt_ff;
      dvd_in       = dvd_ff;
      drem_in      = drem_ff;
      sticky_in    = sticky_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr.valid) begin
         case (csr.data.index)
            CSR_T_MIN: t_min_in = csr.data.value;
            CSR_T_MAX: t_max_in = csr.data.value;
            CSR_STEPS: steps_in = csr.data.value[STEPS_W-1:0];
            default:   steps_in = steps_ff;
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req.data.req_type == REQ_SAMPLE)) begin
               p_in     = req.data.uniform;
               state_in = ST_CHK_FIRST;
            end
         end
         ST_CHK_FIRST: begin
            if (!alu_ge) begin
               res_in.sample_value = t_min_ff;
               res_in.clamp_kind   = KIND_MIN;
               state_in            = ST_OUT;
            end else begin
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (alu_ge) begin
               res_in.sample_value = t_max_ff;
               res_in.clamp_kind   = KIND_MAX;
               state_in            = ST_OUT;
            end else begin
               a_in     = '0;
               b_in     = last_c;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (far_c) begin
               mid_in   = mid_c;
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_READ_LO;
            end
         end
         ST_COMPARE: begin
            if (!alu_ge) begin
               b_in = mid_ff;
            end else begin
               a_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end
         ST_READ_LO: begin
            lo_in    = rd_q_ff;
            rem_in   = alu_sum[VALUE_W-1:0];
            state_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            dsr_in   = alu_sum[VALUE_W-1:0];
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            mag_in      = alu_sum[MAG_W-1:0];
            span_neg_in = alu_sum[MAG_W-1];
            state_in    = ST_MAG;
         end
         ST_MAG: begin
            if (span_neg_ff) begin
               mag_in = alu_sum[MAG_W-1:0];
            end
            cnt_in   = '0;
            frac_in  = '0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            rem_in  = alu_ge ? alu_sum[VALUE_W-1:0] : {rem_ff[VALUE_W-2:0], 1'b0};
            frac_in = {frac_ff[FRAC_W-2:0], alu_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               cnt_in   = '0;
               acc_in   = '0;
               mlt_in   = {a_ff, frac_in};
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = alu_sum[MAG_W:1];
            mlt_in = {alu_sum[0], mlt_ff[POS_W-1:1]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(POS_W - 1)) begin
               cnt_in    = '0;
               dvd_in    = {acc_in, mlt_in[POS_W-1:FRAC_W]};
               sticky_in = |mlt_in[FRAC_W-1:0];
               drem_in   = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            drem_in = alu_ge ? alu_sum[N_W-1:0] : div_shift[N_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], alu_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_in.sample_value = alu_sum[SAMPLE_W-1:0];
            res_in.clamp_kind   = KIND_INTERP;
            state_in            = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mid_ff      <= mid_in;
      lo_ff       <= lo_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      frac_ff     <= frac_in;
      span_neg_ff <= span_neg_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      mlt_ff      <= mlt_in;
      dvd_ff      <= dvd_in;
      drem_ff     <= drem_in;
      sticky_ff   <= sticky_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         t_min_ff     <= T_MIN_RESET;
         t_max_ff     <= T_MAX_RESET;
         steps_ff     <= STEPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         t_min_ff     <= t_min_in;
         t_max_ff     <= t_max_in;
         steps_ff     <= steps_in;
      end
   end

endmodule

@@ rtl/core/icdf_checker.sv @@
module icdf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_kind,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input icdf_pkg::rsp_payload_type rsp_data
);

   import icdf_pkg::*;

   a_reset_drop: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == REQ_SAMPLE) |=> !req_ready)
      else $error("ready right after a sample beat");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == REQ_LOAD) |=> req_ready)
      else $error("not ready after a load beat");

endmodule

bind inverse_cdf_table_sampler icdf_checker u_icdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_kind  (req.data.req_type),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

@@ tb/sv/icdf_sample_checker.sv @@
`timescale 1ns / 100ps

module icdf_sample_checker #(
   parameter int TABLE_DEPTH    = 1024,
   parameter int PROB_FRAC_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  icdf_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  icdf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  icdf_pkg::csr_payload_type csr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        loads_seen,
   output int                        interp_seen,
   output int                        clamp_min_seen,
   output int                        clamp_max_seen
);
   import icdf_pkg::*;

   logic [VALUE_W-1:0]         cdf_copy [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] cfg_t_min;
   logic signed [SAMPLE_W-1:0] cfg_t_max;
   logic [STEPS_W-1:0]         cfg_steps;
   rsp_payload_type            expected_samples [$];
   rsp_payload_type            want;
   rsp_payload_type            got;

   function automatic rsp_payload_type invert_cdf(logic [PROB_W-1:0] p);
      int unsigned        n, a, b, mid;
      logic [VALUE_W-1:0] lo, hi;
      logic [63:0]        num, width, frac, pos, den;
      longint             tmin, tmax, span, res;
      logic [127:0]       mag, prod, quo, rem;
      rsp_payload_type    r;
      if (cfg_steps < 11'd2) n = 2;
      else if (cfg_steps > TABLE_DEPTH) n = TABLE_DEPTH;
      else n = cfg_steps;
      tmin = cfg_t_min;
      tmax = cfg_t_max;
      if (p < cdf_copy[0]) begin
         r.sample_value = cfg_t_min;
         r.clamp_kind   = KIND_MIN;
      end else if (p >= cdf_copy[n-1]) begin
         r.sample_value = cfg_t_max;
         r.clamp_kind   = KIND_MAX;
      end else begin
         a = 0;
         b = n - 1;
         while (b - a > 1) begin
            mid = a + (b - a) / 2;
            if (p < cdf_copy[mid]) b = mid;
            else a = mid;
         end
         lo    = cdf_copy[b-1];
         hi    = cdf_copy[b];
         num   = p;
         num   = (num - lo) << PROB_FRAC_BITS;
         width = hi;
         width = width - lo;
         frac  = num / width;
         pos   = b - 1;
         pos   = (pos << PROB_FRAC_BITS) + frac;
         den   = n;
         den   = den << PROB_FRAC_BITS;
         span  = tmax - tmin;
         if (span < 0) mag = -span;
         else mag = span;
         prod = mag * pos;
         quo  = prod / den;
         rem  = prod % den;
         if (span < 0) res = tmin - longint'(quo[63:0]) - longint'(rem != 0);
         else res = tmin + longint'(quo[63:0]);
         r.sample_value = res[SAMPLE_W-1:0];
         r.clamp_kind   = KIND_INTERP;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_t_min      = T_MIN_RESET;
         cfg_t_max      = T_MAX_RESET;
         cfg_steps      = STEPS_RESET;
         fail_count     = 0;
         loads_seen     = 0;
         interp_seen    = 0;
         clamp_min_seen = 0;
         clamp_max_seen = 0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_samples.size() == 0) begin
               fail_count++;
               $display("%0t unexpected sample beat: expected none, actual %0d kind %0d",
                        $time, got.sample_value, got.clamp_kind);
            end else begin
               want = expected_samples.pop_front();
               if (got.sample_value !== want.sample_value) begin
                  fail_count++;
                  $display("%0t sample_value mismatch: expected %0d, actual %0d",
                           $time, want.sample_value, got.sample_value);
               end
               if (got.clamp_kind !== want.clamp_kind) begin
                  fail_count++;
                  $display("%0t clamp_kind mismatch: expected %0d, actual %0d",
                           $time, want.clamp_kind, got.clamp_kind);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_data.index)
               CSR_T_MIN: cfg_t_min = csr_data.value;
               CSR_T_MAX: cfg_t_max = csr_data.value;
               CSR_STEPS: cfg_steps = csr_data.value[STEPS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_LOAD) begin
               cdf_copy[req_data.entry_index] = req_data.entry_value;
               loads_seen++;
            end else begin
               want = invert_cdf(req_data.uniform);
               expected_samples.push_back(want);
               case (want.clamp_kind)
                  KIND_MIN: clamp_min_seen++;
                  KIND_MAX: clamp_max_seen++;
                  default:  interp_seen++;
               endcase
            end
         end
      end
      pending = expected_samples.size();
   end

endmodule

@@ tb/sv/tb_inverse_cdf_table_sampler.sv @@
`timescale 1ns / 100ps

module tb_inverse_cdf_table_sampler;
   import icdf_pkg::*;

   localparam int TABLE_DEPTH    = 1024;
   localparam int PROB_FRAC_BITS = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [VALUE_W-1:0]     PROB_ONE   = 25'h1000000;
   localparam logic [SAMPLE_W-1:0]    S_MIN      = 32'h8000_0000;
   localparam logic [SAMPLE_W-1:0]    S_MAX      = 32'h7FFF_FFFF;
   localparam int SETTLE_CYCLES = 200;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 800;

   logic clock;
   logic reset;

   icdf_stream_if #(.payload_type(req_payload_type)) req_if ();
   icdf_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();
   icdf_stream_if #(.payload_type(csr_payload_type)) csr_if ();

   int          tx_idle;
   int          rx_idle;
   int          rx_hold;
   int unsigned used_steps;
   int          settings_run;
   logic [SAMPLE_W-1:0] span_end;
   logic [VALUE_W-1:0]  shadow_cdf [TABLE_DEPTH];

   int fail_count;
   int pending;
   int loads_seen;
   int interp_seen;
   int clamp_min_seen;
   int clamp_max_seen;

   inverse_cdf_table_sampler #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   icdf_sample_checker #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_data       (req_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_data       (rsp_if.data),
      .csr_valid      (csr_if.valid),
      .csr_ready      (csr_if.ready),
      .csr_data       (csr_if.data),
      .fail_count     (fail_count),
      .pending        (pending),
      .loads_seen     (loads_seen),
      .interp_seen    (interp_seen),
      .clamp_min_seen (clamp_min_seen),
      .clamp_max_seen (clamp_max_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("** inverse_cdf_table_sampler: FAILED **");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic send_beat(req_payload_type beat);
      while ($urandom_range(99) < tx_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= beat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_entry(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] value);
      req_payload_type beat;
      beat.req_type    = REQ_LOAD;
      beat.entry_index = idx;
      beat.entry_value = value;
      beat.uniform     = PROB_W'($urandom);
      shadow_cdf[idx]  = value;
      send_beat(beat);
   endtask

   task automatic take_sample(logic [PROB_W-1:0] p);
      req_payload_type beat;
      beat.req_type    = REQ_SAMPLE;
      beat.entry_index = INDEX_W'($urandom);
      beat.entry_value = VALUE_W'($urandom_range(PROB_ONE));
      beat.uniform     = p;
      send_beat(beat);
   endtask

   // hold until every sample is back, then let any trailing load settle
   task automatic drain();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [SAMPLE_W-1:0] lo_end, logic [SAMPLE_W-1:0] hi_end,
                            int unsigned steps_raw);
      csr_payload_type writes [4];
      int i;
      writes[0].index = CSR_UNUSED;
      writes[0].value = $urandom;
      writes[1].index = CSR_T_MIN;
      writes[1].value = lo_end;
      writes[2].index = CSR_T_MAX;
      writes[2].value = hi_end;
      writes[3].index = CSR_STEPS;
      writes[3].value = steps_raw;
      drain();
      for (i = 0; i < 4; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.data  <= writes[i];
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
         @(negedge clock);
      end
      csr_if.valid <= 1'b0;
      steps_raw  = steps_raw & 32'h7FF;
      if (steps_raw < 2) used_steps = 2;
      else if (steps_raw > TABLE_DEPTH) used_steps = TABLE_DEPTH;
      else used_steps = steps_raw;
      settings_run++;
   endtask

   // monotonic table over the used entries, sometimes ending exactly at one
   task automatic fill_table();
      int unsigned level, stride, i;
      stride = (1 << PROB_W) / used_steps;
      level  = ($urandom_range(3) == 0) ? 0 : $urandom_range(stride);
      for (i = 0; i < used_steps; i++) begin
         if (i == used_steps - 1 && $urandom_range(1) == 1) level = PROB_ONE;
         load_entry(i[INDEX_W-1:0], level[VALUE_W-1:0]);
         level = level + $urandom_range(2 * stride);
         if (level > PROB_ONE) level = PROB_ONE;
      end
   endtask

   task automatic random_phase(int count);
      int k, pick, probe;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            load_entry(INDEX_W'($urandom_range(TABLE_DEPTH - 1)),
                       VALUE_W'($urandom_range(PROB_ONE)));
         end else begin
            if (pick < 40) begin
               probe = int'(shadow_cdf[$urandom_range(used_steps - 1)]);
               probe = probe + int'($urandom_range(2)) - 1;
               if (probe < 0) probe = 0;
               if (probe > int'(PROB_ONE) - 1) probe = int'(PROB_ONE) - 1;
            end else begin
               probe = $urandom_range(PROB_ONE - 1);
            end
            take_sample(probe[PROB_W-1:0]);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      tx_idle      = 25;
      rx_idle      = 76;
      rx_hold      = 0;
      settings_run = 0;
      used_steps   = TABLE_DEPTH;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two-entry table over the widest range
      configure(S_MIN, S_MAX, 2);
      load_entry(10'd0, 25'h0400000);
      load_entry(10'd1, 25'h0C00000);
      take_sample(24'h000000);
      take_sample(24'h3FFFFF);
      take_sample(24'h400000);
      take_sample(24'h800000);
      take_sample(24'hBFFFFF);
      take_sample(24'hC00000);
      take_sample(24'hFFFFFF);
      load_entry(10'd0, 25'h0000000);
      load_entry(10'd1, PROB_ONE);
      load_entry(INDEX_W'(TABLE_DEPTH - 1), PROB_ONE);
      take_sample(24'h000000);
      take_sample(24'h7FFFFF);
      take_sample(24'hFFFFFF);

      // reversed range over a table that is not monotonic
      configure(S_MAX, S_MIN, 3);
      load_entry(10'd2, 25'h0800000);
      take_sample(24'h000001);
      take_sample(24'h7FFFFF);
      take_sample(24'h800000);
      take_sample(24'hFFFFFF);

      // full table once; later settings reuse its entries
      configure(S_MIN, S_MAX, 2047);
      fill_table();
      random_phase(35);
      configure(T_MIN_RESET, T_MAX_RESET, 16);
      fill_table();
      random_phase(25);
      configure(S_MAX, S_MIN, 0);
      random_phase(15);

      tx_idle = 76;
      rx_idle = 25;
      configure($urandom, $urandom, TABLE_DEPTH);
      random_phase(20);
      configure($urandom, $urandom, 3);
      fill_table();
      rx_hold = HOLD_CYCLES;
      random_phase(25);

      tx_idle = 0;
      rx_idle = 0;
      span_end = $urandom;
      configure(span_end, span_end, 7);
      fill_table();
      random_phase(15);
      configure($urandom, $urandom, $urandom_range(64, 2));
      random_phase(25);

      drain();
      $display("covered %0d register settings, step counts 2 to %0d, %0d table loads",
               settings_run, TABLE_DEPTH, loads_seen);
      $display("samples: %0d interpolated, %0d clamped low, %0d clamped high, %0d missing",
               interp_seen, clamp_min_seen, clamp_max_seen, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("** inverse_cdf_table_sampler: PASSED **");
      end else begin
         $display("** inverse_cdf_table_sampler: FAILED **");
      end
      $finish;
   end

endmodule
